/* sv/lepd_pkg.sv */
`timescale 1ns / 1ps
// Package for the LED effect PWM duty engine: effect codes, widths, duty levels,
// the breathing ramp table and the beat struct between the core and the scaler.
// No dependencies.
package lepd_pkg;

  // Field and register widths
  localparam int EFFECT_W  = 4;
  localparam int DUTY_W    = 14;
  localparam int BRIGHT_W  = 7;
  localparam int PHASE_W   = 6;
  localparam int ALARM_W   = 3;

  // Brightness register limits
  localparam int BRIGHT_MAX   = 100;
  localparam int BRIGHT_RESET = 50;

  // Duty levels before brightness scaling
  localparam int FULL_SCALE  = 10000;
  localparam int LEVEL_HIGH  = 8000;
  localparam int LEVEL_SLEEP = 1500;
  localparam int LEVEL_LOW   = 1000;

  // Animation periods
  localparam int BREATH_STEPS = 50;
  localparam int BLINK_PERIOD = 20;
  localparam int BLINK_ON     = 10;
  localparam int ALARM_ON     = 4;

  // level * brightness fits here (10000 * 100 < 2**20)
  localparam int PROD_W = 20;

  // Divide by 100 as multiply by reciprocal: exact for any PROD_W-bit value
  localparam int        PCT_SHIFT = 27;
  localparam int        RECIP_W   = 21;
  localparam longint    PCT_RECIP = ((64'd1 << PCT_SHIFT) + BRIGHT_MAX - 1) / BRIGHT_MAX;

  // Effect codes; codes from EFF_COUNT up are ignored
  typedef enum logic [EFFECT_W-1:0] {
    EFF_OFF      = 4'd0,
    EFF_GUIDE    = 4'd1,
    EFF_DOCKED   = 4'd2,
    EFF_CHEER    = 4'd3,
    EFF_SLEEP    = 4'd4,
    EFF_BREATH   = 4'd5,
    EFF_SPEAKING = 4'd6,
    EFF_TAROT    = 4'd7,
    EFF_ALARM    = 4'd8
  } effect_t;

  localparam int EFF_COUNT = 9;

  typedef logic [DUTY_W-1:0] level_t;
  typedef level_t breath_lut_t [2**PHASE_W];

  // Breathing level per phase step, capped at full scale
  function automatic breath_lut_t breath_lut();
    breath_lut_t t;
    int          v;
    for (int i = 0; i < 2**PHASE_W; i++) begin
      v = i * FULL_SCALE / BREATH_STEPS;
      if (v > FULL_SCALE) v = FULL_SCALE;
      t[i] = level_t'(v);
    end
    return t;
  endfunction

  localparam breath_lut_t BREATH_LEVEL = breath_lut();

  // Unscaled product beat from the core to the scaler
  typedef struct packed {
    logic              valid;
    logic [PROD_W-1:0] prod;
  } prod_beat_t;

endpackage

/* sv/lepd_item_if.sv */
`timescale 1ns / 1ps
// Input item channel: valid/ready handshake with func and effect payload.
// Depends on lepd_pkg.
interface lepd_item_if;
  import lepd_pkg::*;

  logic                valid;
  logic                ready;
  logic                func;
  logic [EFFECT_W-1:0] effect;

  modport source(output valid, func, effect, input ready);
  modport sink(input valid, func, effect, output ready);
endinterface

/* sv/lepd_result_if.sv */
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with duty and pwm_enable payload.
// Depends on lepd_pkg.
interface lepd_result_if;
  import lepd_pkg::*;

  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] duty;
  logic              pwm_enable;

  modport source(output valid, duty, pwm_enable, input ready);
  modport sink(input valid, duty, pwm_enable, output ready);
endinterface

/* sv/lepd_cfg_if.sv */
`timescale 1ns / 1ps
// Configuration write channel: valid/ready handshake carrying brightness data.
// Depends on lepd_pkg.
interface lepd_cfg_if;
  import lepd_pkg::*;

  logic                valid;
  logic                ready;
  logic [BRIGHT_W-1:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

/* sv/led_effect_pwm_duty_engine.sv */
`timescale 1ns / 1ps
// LED effect PWM duty engine, top level. An accepted item passes through the
// input register, then the product register, then the output register, where
// its result becomes valid. Throughput: one item per cycle;
// stalls only on result backpressure.
// Synchronous active-high reset: effect off, phase 0, rising, brightness 50.
// Depends on lepd_pkg, the three channel interfaces, lepd_core and lepd_scale.
module led_effect_pwm_duty_engine (
  input  logic          clk,
  input  logic          rst,
  lepd_item_if.sink     item,
  lepd_result_if.source result,
  lepd_cfg_if.sink      cfg
);
  import lepd_pkg::*;

  logic [BRIGHT_W-1:0] brightness;
  prod_beat_t          beat;
  logic                beat_take;

  // Brightness register, writes above 100 clamp
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= BRIGHT_W'(BRIGHT_RESET);
    end else if (cfg.valid) begin
      brightness <= (cfg.data > BRIGHT_W'(BRIGHT_MAX)) ? BRIGHT_W'(BRIGHT_MAX) : cfg.data;
    end
  end

  lepd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .brightness (brightness),
    .beat_take  (beat_take),
    .beat       (beat)
  );

  lepd_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .beat      (beat),
    .beat_take (beat_take),
    .result    (result)
  );

endmodule

/* sv/lepd_core.sv */
`timescale 1ns / 1ps
// Effect core: input register, effect/phase state update and the unscaled
// level * brightness product register. Depends on lepd_pkg, lepd_item_if.
module lepd_core (
  input  logic                          clk,
  input  logic                          rst,
  lepd_item_if.sink                     item,
  input  logic [lepd_pkg::BRIGHT_W-1:0] brightness,
  input  logic                          beat_take,
  output lepd_pkg::prod_beat_t          beat
);
  import lepd_pkg::*;

  // Input register
  logic                s1_valid;
  logic                s1_func;
  logic [EFFECT_W-1:0] s1_effect;

  // Effect state
  effect_t             current_effect;
  logic [PHASE_W-1:0]  phase_step;
  logic                rising;

  // Next-state and level logic
  effect_t             effect_next;
  logic [PHASE_W-1:0]  phase_next;
  logic                rising_next;
  logic [PHASE_W-1:0]  phase_inc;
  logic [PHASE_W-1:0]  cycle_next;
  logic                has_result;
  level_t              level;
  logic                use_bright;
  logic [BRIGHT_W-1:0] factor;
  logic                s2_free;
  logic                s1_adv;

  // Flow control: stage 1 moves when the product register is free or draining
  assign s2_free    = !beat.valid || beat_take;
  assign s1_adv     = s1_valid && s2_free;
  assign item.ready = !s1_valid || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
    if (item.ready && item.valid) begin
      s1_func   <= item.func;
      s1_effect <= item.effect;
    end
  end

  assign phase_inc = phase_step + 1'b1;

  // Effect change and tick behavior
  always_comb begin
    effect_next = current_effect;
    phase_next  = phase_step;
    rising_next = rising;
    has_result  = 1'b0;
    level       = '0;
    use_bright  = 1'b1;
    cycle_next  = '0;
    if (s1_func) begin
      if ((s1_effect < EFFECT_W'(EFF_COUNT)) && (s1_effect != current_effect)) begin
        effect_next = effect_t'(s1_effect);
        phase_next  = '0;
        rising_next = 1'b1;
        case (effect_t'(s1_effect))
          EFF_OFF: begin
            has_result = 1'b1;
          end
          EFF_GUIDE, EFF_DOCKED, EFF_CHEER: begin
            has_result = 1'b1;
            level      = level_t'(LEVEL_HIGH);
          end
          EFF_SLEEP: begin
            has_result = 1'b1;
            level      = level_t'(LEVEL_SLEEP);
          end
          default: ;
        endcase
      end
    end else begin
      case (current_effect)
        EFF_BREATH: begin
          // level follows the phase before it moves
          has_result = 1'b1;
          level      = BREATH_LEVEL[phase_step];
          if (rising) begin
            if (phase_inc >= PHASE_W'(BREATH_STEPS)) begin
              phase_next  = PHASE_W'(BREATH_STEPS);
              rising_next = 1'b0;
            end else begin
              phase_next = phase_inc;
            end
          end else if (phase_step == '0) begin
            rising_next = 1'b1;
          end else begin
            phase_next = phase_step - 1'b1;
          end
        end
        EFF_SPEAKING, EFF_TAROT: begin
          // phase stays below the period, so one wrap check is enough
          cycle_next = (phase_inc == PHASE_W'(BLINK_PERIOD)) ? '0 : phase_inc;
          phase_next = cycle_next;
          has_result = 1'b1;
          level      = (cycle_next < PHASE_W'(BLINK_ON)) ? level_t'(LEVEL_HIGH)
                                                         : level_t'(LEVEL_LOW);
        end
        EFF_ALARM: begin
          cycle_next = PHASE_W'(phase_inc[ALARM_W-1:0]);
          phase_next = cycle_next;
          has_result = 1'b1;
          use_bright = 1'b0;
          level      = (cycle_next < PHASE_W'(ALARM_ON)) ? level_t'(FULL_SCALE) : '0;
        end
        default: ;
      endcase
    end
  end

  // Alarm runs at full scale: factor 100 cancels the later divide
  assign factor = use_bright ? brightness : BRIGHT_W'(BRIGHT_MAX);

  // State update and product register
  always_ff @(posedge clk) begin
    if (rst) begin
      current_effect <= EFF_OFF;
      phase_step     <= '0;
      rising         <= 1'b1;
      beat.valid     <= 1'b0;
    end else if (s1_adv) begin
      current_effect <= effect_next;
      phase_step     <= phase_next;
      rising         <= rising_next;
      beat.valid     <= has_result;
    end else if (beat_take) begin
      beat.valid     <= 1'b0;
    end
    if (s1_adv) begin
      beat.prod <= PROD_W'(level) * PROD_W'(factor);
    end
  end

  // Checks
  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    phase_step <= PHASE_W'(BREATH_STEPS))
    else $error("phase_step beyond breathing range");

  a_blink_bound: assert property (@(posedge clk) disable iff (rst)
    (current_effect == EFF_SPEAKING || current_effect == EFF_TAROT)
      |-> phase_step < PHASE_W'(BLINK_PERIOD))
    else $error("blink phase out of period");

  a_alarm_bound: assert property (@(posedge clk) disable iff (rst)
    current_effect == EFF_ALARM |-> phase_step < PHASE_W'(2**ALARM_W))
    else $error("alarm phase out of period");

  a_beat_hold: assert property (@(posedge clk) disable iff (rst)
    beat.valid && !beat_take |=> beat.valid && $stable(beat.prod))
    else $error("product beat dropped or changed while stalled");

endmodule

/* sv/lepd_scale.sv */
`timescale 1ns / 1ps
// Scaler: divides the level * brightness product by 100 and holds the result
// in the output register. Depends on lepd_pkg, lepd_result_if.
module lepd_scale (
  input  logic                 clk,
  input  logic                 rst,
  input  lepd_pkg::prod_beat_t beat,
  output logic                 beat_take,
  lepd_result_if.source        result
);
  import lepd_pkg::*;

  localparam int MUL_W = PROD_W + RECIP_W;

  logic [MUL_W-1:0]  mul;
  logic [DUTY_W-1:0] quot;
  logic [DUTY_W-1:0] duty_next;

  // Output register loads when empty or being drained
  assign beat_take = beat.valid && (!result.valid || result.ready);

  // Divide by 100 via reciprocal multiply, then clamp to full scale
  assign mul       = MUL_W'(beat.prod) * MUL_W'(PCT_RECIP);
  assign quot      = mul[PCT_SHIFT +: DUTY_W];
  assign duty_next = (quot > DUTY_W'(FULL_SCALE)) ? DUTY_W'(FULL_SCALE) : quot;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (beat_take) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
    if (beat_take) begin
      result.duty       <= duty_next;
      result.pwm_enable <= (duty_next != '0);
    end
  end

endmodule
